// ----- hdl/bfm_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the bloom filter membership block
package bfm_pkg;

	localparam int HASH_W      = 32;
	localparam int HASH_FIELDS = 5;
	localparam int HASH_CNT_W  = $clog2(HASH_FIELDS);

	localparam int  BYTE_W    = 8;
	localparam int  BIT_SEL_W = 3;
	localparam logic [BYTE_W-1:0] BIT_ONE = 8'h01;

	localparam int FB_W = 21;
	localparam logic [FB_W-1:0] FB_RESET = 21'd1048576;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_FILTER_BITS = 1'b0;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_CHECK  = 1'b1;

	// remainder unit retires this many dividend bits per cycle
	localparam int DIV_STEP_BITS = 2;
	localparam int DIV_STEPS     = HASH_W / DIV_STEP_BITS;
	localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_MOD,
		ST_READ,
		ST_TEST,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
	} mod_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mod_status_t;

endpackage

// ----- hdl/bfm_ram.sv -----
`timescale 1ns / 1ps
// generic single-port ram with registered read
module bfm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 131072,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/bfm_mod_unit.sv -----
`timescale 1ns / 1ps
// iterative remainder unit: 32-bit dividend modulo a run-time divisor
module bfm_mod_unit #(
	parameter int SIZE_W = 21
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bfm_pkg::mod_ctrl_t          ctrl,
	input  logic [bfm_pkg::HASH_W-1:0]  dividend,
	input  logic [SIZE_W-1:0]           divisor,
	output bfm_pkg::mod_status_t        status,
	output logic [SIZE_W-1:0]           remainder
);

	import bfm_pkg::*;

	logic [HASH_W-1:0]    dvd_q;
	logic [SIZE_W-1:0]    rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [HASH_W-1:0] dvd_d;
	logic [SIZE_W-1:0] rem_d;
	logic [SIZE_W:0]   trial;

	// restoring steps: remainder stays below the divisor, so one spare bit suffices
	always_comb begin
		dvd_d = dvd_q;
		rem_d = rem_q;
		trial = '0;
		for (int j = 0; j < DIV_STEP_BITS; j++) begin
			trial = {rem_d, dvd_d[HASH_W-1]};
			dvd_d = {dvd_d[HASH_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				trial = trial - {1'b0, divisor};
			end
			rem_d = trial[SIZE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_d;
			rem_q <= rem_d;
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign remainder   = rem_q;

endmodule

// ----- hdl/bloom_filter_membership.sv -----
`timescale 1ns / 1ps
// bloom filter membership top level: sequencer, config register and bit store
//
// Each key beat carries five 32-bit hashes and a mode (insert or check). Every hash is
// reduced modulo the configured filter size by a shared remainder unit that retires two
// bits a cycle, and the resulting bit is set or tested in a byte-wide single-port store.
// One hash goes through launch, the remainder unit, a store read and a test or write-back,
// and a key examines its hashes in turn: all of them on insert, up to the first clear
// bit on check. One key is in flight at a time; a finished result waits in an output
// register while the next key is taken. After reset a clearing pass writes the store
// one byte a cycle and no key is accepted until it ends; the register port works
// throughout. A filter size of zero or above MAX_FILTER_BITS means MAX_FILTER_BITS.
module bloom_filter_membership #(
	parameter longint unsigned MAX_FILTER_BITS = 1048576,
	parameter int              HASH_COUNT      = 5
) (
	input  logic         clk,
	input  logic         arst_n,

	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [159:0] s_tdata,   // hash_a, hash_b, hash_c, hash_d, hash_e
	input  logic [0:0]   s_tuser,   // mode

	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   m_tdata,   // present, zero fill

	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	import bfm_pkg::*;

	localparam longint unsigned STORE_BYTES = (MAX_FILTER_BITS + 7) / 8;
	localparam int SIZE_W    = $clog2(MAX_FILTER_BITS + 1);
	localparam int ADDR_W    = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int HASH_USED = (HASH_COUNT > HASH_FIELDS) ? HASH_FIELDS : HASH_COUNT;
	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(STORE_BYTES - 1);

	state_t state_q, state_d;

	logic [FB_W-1:0]       fb_q;
	logic [SIZE_W-1:0]     eff_size;
	logic [ADDR_W-1:0]     clr_addr_q;
	logic [HASH_W-1:0]     hash_q [HASH_FIELDS];
	logic [HASH_CNT_W-1:0] hash_cnt_q;
	logic                  check_q;
	logic                  present_q;
	logic                  out_valid_q;
	logic                  out_present_q;

	mod_ctrl_t         mod_ctrl;
	mod_status_t       mod_status;
	logic [SIZE_W-1:0] mod_rem;

	logic              ram_we;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_addr;
	logic [BYTE_W-1:0] ram_wdata;
	logic [BYTE_W-1:0] ram_rdata;

	logic [ADDR_W-1:0] byte_addr;
	logic [BYTE_W-1:0] bit_mask;
	logic              bit_hit;
	logic              hash_last;
	logic              s_accept;
	logic              out_load;
	logic              cfg_we;

	// register port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite
		&& (paddr[APB_ADDR_W-1:2] == REG_FILTER_BITS);

	always_comb begin
		prdata = '0;
		if (paddr[APB_ADDR_W-1:2] == REG_FILTER_BITS) begin
			prdata = APB_DATA_W'(fb_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_q <= FB_RESET;
		end else if (cfg_we) begin
			fb_q <= pwdata[FB_W-1:0];
		end
	end

	// zero or oversize falls back to the full store
	always_comb begin
		if (fb_q == '0 || 64'(fb_q) > MAX_FILTER_BITS) begin
			eff_size = SIZE_W'(MAX_FILTER_BITS);
		end else begin
			eff_size = SIZE_W'(fb_q);
		end
	end

	bfm_mod_unit #(
		.SIZE_W(SIZE_W)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (mod_ctrl),
		.dividend  (hash_q[0]),
		.divisor   (eff_size),
		.status    (mod_status),
		.remainder (mod_rem)
	);

	bfm_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(int'(STORE_BYTES))
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign byte_addr = ADDR_W'(mod_rem >> BIT_SEL_W);
	assign bit_mask  = BYTE_W'(BIT_ONE << mod_rem[BIT_SEL_W-1:0]);
	assign bit_hit   = |(ram_rdata & bit_mask);
	assign hash_last = (hash_cnt_q == HASH_CNT_W'(HASH_USED - 1));

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		mod_ctrl.start = 1'b0;
		ram_we         = 1'b0;
		ram_re         = 1'b0;
		ram_addr       = byte_addr;
		ram_wdata      = ram_rdata | bit_mask;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_addr_q;
				ram_wdata = '0;
				if (clr_addr_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				mod_ctrl.start = 1'b1;
				state_d        = ST_MOD;
			end
			ST_MOD: begin
				if (mod_status.done) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				ram_re  = 1'b1;
				state_d = ST_TEST;
			end
			ST_TEST: begin
				// insert writes back the byte with the bit set; check stops at a clear bit
				ram_we = (check_q == MODE_INSERT);
				if (hash_last || (check_q == MODE_CHECK && !bit_hit)) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_START;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			hash_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (s_accept) begin
				hash_cnt_q <= '0;
			end else if (state_q == ST_TEST) begin
				hash_cnt_q <= hash_cnt_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			hash_q[0] <= s_tdata[31:0];
			hash_q[1] <= s_tdata[63:32];
			hash_q[2] <= s_tdata[95:64];
			hash_q[3] <= s_tdata[127:96];
			hash_q[4] <= s_tdata[159:128];
			check_q   <= s_tuser[0];
			present_q <= (s_tuser[0] == MODE_CHECK);
		end else if (state_q == ST_TEST) begin
			// next hash moves down to the remainder unit's input
			for (int i = 0; i < HASH_FIELDS - 1; i++) begin
				hash_q[i] <= hash_q[i+1];
			end
			if (check_q == MODE_CHECK && !bit_hit) begin
				present_q <= 1'b0;
			end
		end
		if (out_load) begin
			out_present_q <= present_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_present_q};

`ifndef SYNTHESIS
	a_no_key_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !s_tready)
		else $error("key taken during store clearing");

	a_store_write_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || (state_q == ST_TEST && check_q == MODE_INSERT)))
		else $error("store written outside clear or insert");

	a_mod_launch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_START) |=> mod_status.busy)
		else $error("remainder unit did not start");

	a_mod_done_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		mod_status.done |-> (state_q == ST_MOD))
		else $error("remainder finished outside wait state");
`endif

endmodule

// ----- tb/bloom_filter_membership_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the bloom filter membership block
module bloom_filter_membership_tb;

	import bfm_pkg::*;

	localparam longint unsigned MAX_BITS = 1048576;
	localparam int HASH_COUNT  = 5;
	localparam int HASH_USED   = (HASH_COUNT > HASH_FIELDS) ? HASH_FIELDS : HASH_COUNT;
	localparam int STORE_BYTES = int'((MAX_BITS + 7) / BYTE_W);
	localparam int KEY_W       = HASH_W * HASH_FIELDS;

	localparam logic [APB_ADDR_W-1:0] FILTER_BITS_ADDR = {REG_FILTER_BITS, 2'b00};
	localparam logic [APB_ADDR_W-1:0] SPARE_REG_ADDR   = {~REG_FILTER_BITS, 2'b00};

	localparam int RESET_CYCLES   = 12;
	localparam int IDLE_PCT       = 19;
	localparam int HOLD_OFF_CYCLES = 800;
	localparam int DRAIN_CYCLES   = 300;
	// the clearing pass after reset counts against this watchdog limit
	localparam int WATCHDOG_LIMIT = 400000;
	localparam int KNOWN_KEYS_MAX = 64;

	class bloom_scoreboard;
		bit [BYTE_W-1:0] store_bytes [STORE_BYTES];
		logic [FB_W-1:0] filter_bits = FB_RESET;
		bit              expected_present [$];
		int unsigned     mismatches = 0;

		// mirrors the block: sets or tests the indexed bits, returns present
		function bit apply_key(logic mode, logic [KEY_W-1:0] hashes);
			longint unsigned modulus;
			longint unsigned idx;
			bit              hit;
			modulus = (filter_bits == 0 || filter_bits > MAX_BITS) ? MAX_BITS : filter_bits;
			hit = (mode == MODE_CHECK);
			for (int i = 0; i < HASH_USED; i++) begin
				idx = hashes[i*HASH_W +: HASH_W] % modulus;
				if (mode == MODE_CHECK) begin
					// scan ends at the first clear bit
					if (!store_bytes[idx / BYTE_W][idx % BYTE_W]) begin
						hit = 1'b0;
						break;
					end
				end else begin
					store_bytes[idx / BYTE_W][idx % BYTE_W] = 1'b1;
				end
			end
			return hit;
		endfunction

		function void note_key(logic mode, logic [KEY_W-1:0] hashes);
			expected_present.push_back(apply_key(mode, hashes));
		endfunction

		function void check_present(logic [7:0] beat);
			logic [7:0] want;
			if (expected_present.size() == 0) begin
				$display("%0t: result beat with none pending: expected none, actual %h",
					$time, beat);
				mismatches++;
			end else begin
				want = {7'b0, expected_present.pop_front()};
				if (beat !== want) begin
					$display("%0t: present mismatch: expected %h, actual %h",
						$time, want, beat);
					mismatches++;
				end
			end
		endfunction

		function int pending();
			return expected_present.size();
		endfunction
	endclass

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [KEY_W-1:0]      s_tdata  = '0;   // hash_a, hash_b, hash_c, hash_d, hash_e
	logic [0:0]            s_tuser  = '0;   // mode
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [7:0]            m_tdata;         // present, zero fill
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [APB_ADDR_W-1:0] paddr    = '0;
	logic [APB_DATA_W-1:0] pwdata   = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	bloom_scoreboard  sb = new();
	logic [KEY_W-1:0] known_keys [$];
	bit               tx_steady    = 1'b0;
	bit               rx_steady    = 1'b0;
	bit               hold_off_req = 1'b0;
	int unsigned      idle_cycles  = 0;

	bloom_filter_membership #(
		.MAX_FILTER_BITS(MAX_BITS),
		.HASH_COUNT     (HASH_COUNT)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// result side: checks each beat and paces m_tready
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_present(m_tdata);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			m_tready <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	task automatic send_key(input logic mode, input logic [KEY_W-1:0] hashes);
		while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= hashes;
		s_tuser  <= mode;
		do @(posedge clk); while (!s_tready);
		sb.note_key(mode, hashes);
	endtask

	task automatic send_random_key();
		logic [KEY_W-1:0] key;
		int unsigned      r;
		r   = $urandom_range(99);
		key = {$urandom, $urandom, $urandom, $urandom, $urandom};
		if (r < 35 || known_keys.size() == 0) begin
			known_keys.push_back(key);
			if (known_keys.size() > KNOWN_KEYS_MAX)
				known_keys.delete(0);
			send_key(MODE_INSERT, key);
		end else if (r < 85) begin
			key = known_keys[$urandom_range(known_keys.size() - 1)];
			// a stored key with one hash disturbed
			if (r >= 65)
				key[$urandom_range(HASH_FIELDS - 1)*HASH_W +: HASH_W] = $urandom;
			send_key(MODE_CHECK, key);
		end else begin
			send_key(MODE_CHECK, key);
		end
	endtask

	task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr[APB_ADDR_W-1:2] == REG_FILTER_BITS)
			sb.filter_bits = value[FB_W-1:0];
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic run_phase(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] value,
		input int unsigned n_keys);
		wait_drained();
		write_reg(addr, value);
		repeat (n_keys) send_random_key();
		s_tvalid <= 1'b0;
	endtask

	initial begin
		logic [KEY_W-1:0] probe;
		logic [KEY_W-1:0] dkey;
		dkey = {32'h8000_0000, 32'hDEAD_BEEF, 32'd12345, 32'h0010_0007, 32'd8};
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// store must read empty after the clearing pass
		send_key(MODE_CHECK, '0);
		send_key(MODE_CHECK, '1);
		send_key(MODE_INSERT, '0);
		send_key(MODE_CHECK, '0);
		send_key(MODE_INSERT, '1);
		send_key(MODE_CHECK, '1);
		send_key(MODE_CHECK, {32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0});
		send_key(MODE_INSERT, dkey);
		send_key(MODE_CHECK, dkey);
		// first clear bit at each hash position in turn
		for (int j = 0; j < HASH_FIELDS; j++) begin
			probe = dkey;
			probe[j*HASH_W +: HASH_W] = 32'd5;
			send_key(MODE_CHECK, probe);
		end
		// hashes one filter size apart land on the same bits
		for (int j = 0; j < HASH_FIELDS; j++)
			probe[j*HASH_W +: HASH_W] = dkey[j*HASH_W +: HASH_W] + 32'h0010_0000;
		send_key(MODE_CHECK, probe);
		send_key(MODE_INSERT, {HASH_FIELDS{32'd3}});
		send_key(MODE_CHECK, {HASH_FIELDS{32'd3}});
		s_tvalid <= 1'b0;

		run_phase(FILTER_BITS_ADDR, 32'd1, 120);
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		run_phase(FILTER_BITS_ADDR, 32'd0, 200);
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		run_phase(SPARE_REG_ADDR, 32'd8, 80);
		hold_off_req = 1'b1;
		run_phase(FILTER_BITS_ADDR, 32'hFFFF_FFFF, 150);
		run_phase(FILTER_BITS_ADDR, 32'd8, 120);
		run_phase(FILTER_BITS_ADDR, 32'd13, 120);
		run_phase(FILTER_BITS_ADDR, 32'd1000, 200);
		run_phase(FILTER_BITS_ADDR, 32'd1048577, 100);
		run_phase(FILTER_BITS_ADDR, $urandom_range(1048576, 1), 200);
		run_phase(FILTER_BITS_ADDR, 32'd1048575, 150);
		run_phase(FILTER_BITS_ADDR, 32'd1048576, 130);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
